@@ rtl/bolist_pkg.sv @@
// bolist_pkg: shared types, request and status codes for the ordered list engine
// depends on nothing; imported by bolist_cell, bounded_ordered_list_engine_core, the checker and the testbench
`default_nettype none

package bolist_pkg;

    // field widths of the stream items
    localparam int FUNC_W    = 3;
    localparam int VALUE_W   = 32;
    localparam int POS_W     = 7;
    localparam int STATUS_W  = 2;
    localparam int OUT_CNT_W = 7;

    // default number of cells in the chain
    localparam int DEFAULT_CAPACITY = 64;

    // request codes
    localparam logic [FUNC_W-1:0] FUNC_INS_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_INS_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_DELETE    = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH    = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_REVERSE   = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_POS = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd3;

    // operation broadcast to every cell of the chain
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_DELETE,
        OP_COMPARE,
        OP_SCAN_DOWN,
        OP_SCAN_UP
    } cell_op_t;

    typedef struct packed {
        cell_op_t                   op;
        logic signed [VALUE_W-1:0]  value;
    } cell_cmd_t;

    // controller states
    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

endpackage

`default_nettype wire

@@ rtl/bolist_cell.sv @@
// bolist_cell: one entry of the list chain with its data word and search match flag
// depends on bolist_pkg; instantiated once per entry by the core
`default_nettype none

module bolist_cell #(
    parameter int CNT_W = 7
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire bolist_pkg::cell_cmd_t                 cmd,
    input  wire logic [CNT_W-1:0]                      cell_idx,
    input  wire logic [CNT_W-1:0]                      count,
    input  wire logic [CNT_W-1:0]                      del_off,
    input  wire logic signed [bolist_pkg::VALUE_W-1:0] prev_data,
    input  wire logic signed [bolist_pkg::VALUE_W-1:0] next_data,
    input  wire logic                                  prev_match,
    input  wire logic                                  next_match,
    output logic signed [bolist_pkg::VALUE_W-1:0]      data_out,
    output logic                                       match_out
);
    import bolist_pkg::*;

    logic signed [VALUE_W-1:0] data_reg;
    logic signed [VALUE_W-1:0] data_next;
    logic                      match_reg;
    logic                      match_next;
    logic                      above_del;

    // cell lies at or above the deleted entry and below the last one
    assign above_del = (cell_idx >= del_off) &&
                       (({1'b0, cell_idx} + (CNT_W+1)'(1)) < {1'b0, count});

    // per-cell action for the broadcast operation
    always_comb begin
        data_next  = data_reg;
        match_next = match_reg;
        unique case (cmd.op)
            OP_HOLD: begin
            end
            OP_PUSH_FRONT: begin
                data_next = (cell_idx == '0) ? cmd.value : prev_data;
            end
            OP_PUSH_BACK: begin
                if (cell_idx == count) begin
                    data_next = cmd.value;
                end
            end
            OP_DELETE: begin
                if (above_del) begin
                    data_next = next_data;
                end
            end
            OP_COMPARE: begin
                match_next = (cell_idx < count) && (data_reg == cmd.value);
            end
            OP_SCAN_DOWN: begin
                match_next = next_match;
            end
            OP_SCAN_UP: begin
                match_next = prev_match;
            end
            default: begin
            end
        endcase
    end

    // data word, no reset needed
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    // match flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg <= 1'b0;
        end else begin
            match_reg <= match_next;
        end
    end

    assign data_out  = data_reg;
    assign match_out = match_reg;

`ifndef NO_ASSERTIONS
    // entries past the end never report a match
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_COMPARE) && (cell_idx >= count) |=> !match_reg)
        else $error("match flagged beyond list end");

    // the head cell takes the new value on a front insert
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_PUSH_FRONT) && (cell_idx == '0) |=> data_reg == $past(cmd.value))
        else $error("head cell lost front insert");

    // cells outside the delete window keep their data
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_DELETE) && !above_del |=> $stable(data_reg))
        else $error("cell outside delete window changed");
`endif

endmodule

`default_nettype wire

@@ rtl/bounded_ordered_list_engine_core.sv @@
// bounded_ordered_list_engine_core: ordered list of signed words held in a chain of cells
// depends on bolist_pkg and bolist_cell
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid, s_tready | s_tdata: func, item_value, position
//  m_      | out | m_tvalid, m_tready | m_tdata: status, found_position, length
//
// inserts, deletes and reverses finish without a scan once the held request starts
// a search compares all cells at once, then walks the match flags along the chain
// one cell per cycle: over the list length, or over the whole chain when the list is reversed
// a request is buffered while an earlier result waits; reset is synchronous, active low
// reset empties the list, the cell data words are not cleared
`default_nettype none

module bounded_ordered_list_engine_core #(
    parameter int CAPACITY = bolist_pkg::DEFAULT_CAPACITY
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [2:0] func, [34:3] item_value, [41:35] position, [47:42] zero
    input  wire logic [47:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [1:0] status, [8:2] found_position, [15:9] length
    output logic [15:0]      m_tdata
);
    import bolist_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // request buffer
    logic                      in_full_reg;
    logic                      in_full_next;
    logic [FUNC_W-1:0]         in_func_reg;
    logic signed [VALUE_W-1:0] in_value_reg;
    logic [POS_W-1:0]          in_pos_reg;
    logic                      s_accept;

    // list control state
    state_t                    state_reg;
    state_t                    state_next;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      rev_reg;
    logic                      rev_next;
    logic [IDX_W-1:0]          scan_off_reg;
    logic [IDX_W-1:0]          scan_off_next;

    // result register
    logic                      m_tvalid_reg;
    logic                      m_tvalid_next;
    logic [15:0]               m_tdata_reg;
    logic [15:0]               m_tdata_next;

    logic                      go;
    logic                      finish;
    logic [STATUS_W-1:0]       res_status;
    logic [CNT_W-1:0]          res_found;
    logic [CNT_W-1:0]          del_off;
    logic [CMP_W-1:0]          pos_ext;
    logic [CMP_W-1:0]          cnt_ext;
    logic                      head_match;
    logic                      scan_last;
    cell_cmd_t                 cmd;

    // chain wiring
    logic signed [VALUE_W-1:0] data_q     [CAPACITY];
    logic                      match_q    [CAPACITY];
    logic signed [VALUE_W-1:0] prev_data  [CAPACITY];
    logic signed [VALUE_W-1:0] next_data  [CAPACITY];
    logic                      prev_match [CAPACITY];
    logic                      next_match [CAPACITY];

    assign s_tready = !in_full_reg;
    assign s_accept = s_tvalid && !in_full_reg;
    assign go       = in_full_reg && (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);

    assign pos_ext    = CMP_W'(in_pos_reg);
    assign cnt_ext    = CMP_W'(count_reg);
    assign del_off    = rev_reg ? (count_reg - CNT_W'(in_pos_reg))
                                : (CNT_W'(in_pos_reg) - CNT_W'(1));
    assign head_match = rev_reg ? match_q[CAPACITY-1] : match_q[0];
    assign scan_last  = rev_reg ? (scan_off_reg == '0)
                                : (CNT_W'(scan_off_reg) == (count_reg - CNT_W'(1)));

    // request sequencing and result forming
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        rev_next      = rev_reg;
        scan_off_next = scan_off_reg;
        cmd.op        = OP_HOLD;
        cmd.value     = in_value_reg;
        finish        = 1'b0;
        res_status    = STATUS_OK;
        res_found     = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (go) begin
                    finish = 1'b1;
                    if ((in_func_reg == FUNC_INS_FRONT) || (in_func_reg == FUNC_INS_BACK)) begin
                        if (count_reg == CNT_W'(CAPACITY)) begin
                            res_status = STATUS_FULL;
                        end else begin
                            cmd.op = ((in_func_reg == FUNC_INS_FRONT) != rev_reg)
                                     ? OP_PUSH_FRONT : OP_PUSH_BACK;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end else if (in_func_reg == FUNC_DELETE) begin
                        if ((pos_ext == '0) || (pos_ext > cnt_ext)) begin
                            res_status = STATUS_BAD_POS;
                        end else begin
                            cmd.op     = OP_DELETE;
                            count_next = count_reg - CNT_W'(1);
                        end
                    end else if (in_func_reg == FUNC_SEARCH) begin
                        if (count_reg == '0) begin
                            res_status = STATUS_EMPTY;
                        end else begin
                            finish        = 1'b0;
                            cmd.op        = OP_COMPARE;
                            state_next    = ST_SCAN;
                            scan_off_next = rev_reg ? IDX_W'(CAPACITY - 1) : '0;
                        end
                    end else if (in_func_reg == FUNC_REVERSE) begin
                        rev_next = !rev_reg;
                    end
                end
            end
            ST_SCAN: begin
                if (head_match) begin
                    finish     = 1'b1;
                    state_next = ST_IDLE;
                    res_found  = rev_reg ? (count_reg - CNT_W'(scan_off_reg))
                                         : (CNT_W'(scan_off_reg) + CNT_W'(1));
                end else if (scan_last) begin
                    finish     = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    cmd.op        = rev_reg ? OP_SCAN_UP : OP_SCAN_DOWN;
                    scan_off_next = rev_reg ? (scan_off_reg - IDX_W'(1))
                                            : (scan_off_reg + IDX_W'(1));
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // buffer and result handshakes
    always_comb begin
        in_full_next  = in_full_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        if (s_accept) begin
            in_full_next = 1'b1;
        end else if (finish) begin
            in_full_next = 1'b0;
        end
        if (finish) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {OUT_CNT_W'(count_next), OUT_CNT_W'(res_found), res_status};
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            rev_reg      <= 1'b0;
            scan_off_reg <= '0;
            in_full_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rev_reg      <= rev_next;
            scan_off_reg <= scan_off_next;
            in_full_reg  <= in_full_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_func_reg  <= s_tdata[2:0];
            in_value_reg <= s_tdata[34:3];
            in_pos_reg   <= s_tdata[41:35];
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // chain of cells, each wired to its neighbors, with the chain ends tied to zero
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        if (i == 0) begin : g_first
            assign prev_data[i]  = '0;
            assign prev_match[i] = 1'b0;
        end else begin : g_mid_lo
            assign prev_data[i]  = data_q[i-1];
            assign prev_match[i] = match_q[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign next_data[i]  = '0;
            assign next_match[i] = 1'b0;
        end else begin : g_mid_hi
            assign next_data[i]  = data_q[i+1];
            assign next_match[i] = match_q[i+1];
        end

        bolist_cell #(
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (cmd),
            .cell_idx   (CNT_W'(i)),
            .count      (count_reg),
            .del_off    (del_off),
            .prev_data  (prev_data[i]),
            .next_data  (next_data[i]),
            .prev_match (prev_match[i]),
            .next_match (next_match[i]),
            .data_out   (data_q[i]),
            .match_out  (match_q[i])
        );
    end

`ifndef NO_ASSERTIONS
    // list never grows past its capacity
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // a search only runs with its request held and the result slot empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> in_full_reg && !m_tvalid_reg)
        else $error("search running without held request or with result pending");

    // forward scan stays inside the list
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) && !rev_reg |-> CNT_W'(scan_off_reg) < count_reg)
        else $error("forward scan ran past list end");
`endif

endmodule

`default_nettype wire

@@ test/bolist_result_checker.sv @@
// bolist_result_checker: watches both stream channels of the ordered list engine,
// predicts one result per accepted request and compares it field by field
// depends on bolist_pkg for field widths, request and status codes
module bolist_result_checker #(
    parameter int CAPACITY = bolist_pkg::DEFAULT_CAPACITY
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    // [2:0] func, [34:3] item_value, [41:35] position, [47:42] zero
    input  wire logic [47:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    // [1:0] status, [8:2] found_position, [15:9] length
    input  wire logic [15:0] m_tdata,
    output int               mismatch_count,
    output int               results_due
);
    import bolist_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // request fields, last field in the lowest bits
    typedef struct packed {
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] item_value;
        logic [FUNC_W-1:0]         func;
    } list_request_t;

    typedef struct packed {
        logic [OUT_CNT_W-1:0] length;
        logic [OUT_CNT_W-1:0] found_position;
        logic [STATUS_W-1:0]  status;
    } list_outcome_t;

    // shadow list in storage order; logical order runs backwards when flipped
    logic signed [VALUE_W-1:0] shadow_list[$];
    logic                      shadow_flipped;
    list_outcome_t             outcome_q[$];

    // apply one request to the shadow list and return the result it must give
    function automatic list_outcome_t apply_request(input list_request_t req);
        list_outcome_t res;
        int            n;
        int            slot;
        res = '0;
        n = shadow_list.size();
        case (req.func)
            FUNC_INS_FRONT, FUNC_INS_BACK: begin
                if (n >= CAPACITY) begin
                    res.status = STATUS_FULL;
                end else if ((req.func == FUNC_INS_FRONT) != shadow_flipped) begin
                    shadow_list.push_front(req.item_value);
                end else begin
                    shadow_list.push_back(req.item_value);
                end
            end
            FUNC_DELETE: begin
                if (req.position == 0 || int'(req.position) > n) begin
                    res.status = STATUS_BAD_POS;
                end else begin
                    slot = shadow_flipped ? n - int'(req.position) : int'(req.position) - 1;
                    shadow_list.delete(slot);
                end
            end
            FUNC_SEARCH: begin
                if (n == 0) begin
                    res.status = STATUS_EMPTY;
                end else begin
                    // first match in logical order
                    for (int k = 0; k < n; k++) begin
                        slot = shadow_flipped ? n - 1 - k : k;
                        if (shadow_list[slot] == req.item_value) begin
                            res.found_position = OUT_CNT_W'(k + 1);
                            break;
                        end
                    end
                end
            end
            FUNC_REVERSE: begin
                shadow_flipped = !shadow_flipped;
            end
            default: begin
                // spare codes leave everything alone
            end
        endcase
        res.length = OUT_CNT_W'(shadow_list.size());
        return res;
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endfunction

    // results are checked before the request of the same edge is taken in
    always @(posedge aclk) begin : watch
        list_outcome_t got;
        list_outcome_t want;
        if (!aresetn) begin
            shadow_list.delete();
            outcome_q.delete();
            shadow_flipped = 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (outcome_q.size() == 0) begin
                    $error("result transfer %h with no request outstanding", m_tdata);
                    mismatch_count++;
                end else begin
                    want = outcome_q.pop_front();
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("found_position", 32'(want.found_position),
                                32'(got.found_position));
                    check_field("length", 32'(want.length), 32'(got.length));
                end
            end
            if (s_tvalid && s_tready) begin
                outcome_q.push_back(apply_request(list_request_t'(s_tdata[41:0])));
            end
        end
        results_due = outcome_q.size();
    end

endmodule

@@ test/bounded_ordered_list_engine_core_tb.sv @@
// bounded_ordered_list_engine_core_tb: drives list requests into the engine, directed
// corner cases first and then random grow, shrink and mixed episodes
// depends on bolist_pkg, bounded_ordered_list_engine_core and bolist_result_checker
module bounded_ordered_list_engine_core_tb;
    import bolist_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY         = DEFAULT_CAPACITY;
    localparam int RANDOM_ITEMS     = 2000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES     = 2 * CAPACITY + 20;
    localparam int POOL_DEPTH       = 32;

    // func codes the engine must ignore
    localparam logic [FUNC_W-1:0] FUNC_SPARE_FIRST = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_LAST  = 3'd7;

    typedef enum int {
        EPISODE_GROW,
        EPISODE_SHRINK,
        EPISODE_MIXED
    } episode_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [47:0] s_tdata  = '0;
    logic        m_tready = 1'b0;
    wire logic        s_tready;
    wire logic        m_tvalid;
    wire logic [15:0] m_tdata;

    int mismatch_count;
    int results_due;

    bit gaps_on       = 1'b1;
    bit long_hold_req = 1'b0;

    // rough picture of the list, used only to shape the stimulus
    int                        list_len;
    logic signed [VALUE_W-1:0] value_pool[$];

    bounded_ordered_list_engine_core #(
        .CAPACITY(CAPACITY)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    bolist_result_checker #(
        .CAPACITY(CAPACITY)
    ) checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .mismatch_count(mismatch_count),
        .results_due   (results_due)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // one request transfer, with an optional idle burst ahead of it
    task automatic issue_request(input logic [FUNC_W-1:0] func,
                                 input logic signed [VALUE_W-1:0] value,
                                 input logic [POS_W-1:0] pos);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, pos, value, func};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        case (func)
            FUNC_INS_FRONT, FUNC_INS_BACK: begin
                if (list_len < CAPACITY) begin
                    list_len++;
                    value_pool.push_back(value);
                    if (value_pool.size() > POOL_DEPTH) void'(value_pool.pop_front());
                end
            end
            FUNC_DELETE: begin
                if (pos != 0 && int'(pos) <= list_len) list_len--;
            end
            default: begin
            end
        endcase
    endtask

    // extremes, small values that repeat, and full-range values
    function automatic logic signed [VALUE_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3) return 32'sh7FFF_FFFF;
        if (roll < 6) return 32'sh8000_0000;
        if (roll < 9) return -32'sd1;
        if (roll < 40) return $urandom_range(0, 7);
        return $urandom;
    endfunction

    task automatic random_request(input episode_t episode);
        int                        roll;
        int                        ins_w;
        int                        del_w;
        logic [FUNC_W-1:0]         func;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          pos;
        case (episode)
            EPISODE_GROW:   begin ins_w = 65; del_w = 10; end
            EPISODE_SHRINK: begin ins_w = 15; del_w = 55; end
            default:        begin ins_w = 40; del_w = 25; end
        endcase
        value = pick_value();
        pos   = POS_W'($urandom_range(0, 127));
        roll  = $urandom_range(0, 99);
        if (roll < ins_w) begin
            func = $urandom_range(0, 1) ? FUNC_INS_BACK : FUNC_INS_FRONT;
        end else if (roll < ins_w + del_w) begin
            func = FUNC_DELETE;
            if (list_len > 0 && $urandom_range(0, 4) != 0)
                pos = POS_W'($urandom_range(1, list_len));
        end else if (roll < 91) begin
            func = FUNC_SEARCH;
            if (value_pool.size() > 0 && $urandom_range(0, 9) < 6)
                value = value_pool[$urandom_range(0, value_pool.size() - 1)];
        end else if (roll < 98) begin
            func = FUNC_REVERSE;
        end else begin
            func = FUNC_W'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
        end
        issue_request(func, value, pos);
    endtask

    // result side: short random stalls, plus one long hold-off on request
    initial begin : result_sink
        bit long_hold_done;
        long_hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (long_hold_req && !long_hold_done) begin
                long_hold_done = 1'b1;
                m_tready <= 1'b0;
                for (int c = 0; c < LONG_HOLD_CYCLES; c++) @(posedge aclk);
                m_tready <= 1'b1;
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // stimulus and verdict
    initial begin : stimulus
        int       sent;
        int       burst;
        episode_t episode;
        list_len = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed corners: empty list, extremes, duplicates, reversal, bad positions
        issue_request(FUNC_SEARCH, 32'sd0, 7'd0);
        issue_request(FUNC_DELETE, 32'sd0, 7'd0);
        issue_request(FUNC_DELETE, 32'sd0, 7'd1);
        issue_request(FUNC_REVERSE, 32'sd0, 7'd0);
        issue_request(FUNC_INS_FRONT, 32'sh7FFF_FFFF, 7'd0);
        issue_request(FUNC_REVERSE, 32'sd0, 7'd127);
        issue_request(FUNC_INS_BACK, 32'sh8000_0000, 7'd0);
        issue_request(FUNC_INS_FRONT, -32'sd1, 7'd127);
        issue_request(FUNC_INS_BACK, 32'sd0, 7'd0);
        issue_request(FUNC_INS_FRONT, 32'sh7FFF_FFFF, 7'd0);
        issue_request(FUNC_SEARCH, 32'sh7FFF_FFFF, 7'd0);
        issue_request(FUNC_SEARCH, 32'sh8000_0000, 7'd0);
        issue_request(FUNC_SEARCH, 32'sd12345, 7'd0);
        issue_request(FUNC_REVERSE, 32'sd0, 7'd0);
        issue_request(FUNC_SEARCH, 32'sh7FFF_FFFF, 7'd0);
        issue_request(FUNC_DELETE, 32'sd0, 7'd127);
        issue_request(FUNC_DELETE, 32'sd0, 7'd6);
        issue_request(FUNC_DELETE, 32'sd0, 7'd5);
        issue_request(FUNC_DELETE, 32'sd0, 7'd1);
        for (int f = FUNC_SPARE_FIRST; f <= FUNC_SPARE_LAST; f++)
            issue_request(FUNC_W'(f), -32'sd1, 7'd127);
        issue_request(FUNC_SEARCH, -32'sd1, 7'd0);

        // random episodes that grow the list toward full and shrink it again
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            episode = episode_t'($urandom_range(0, 2));
            burst   = (episode == EPISODE_GROW) ? $urandom_range(40, 160)
                                                : $urandom_range(20, 120);
            for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
                if (sent == RANDOM_ITEMS / 2) long_hold_req = 1'b1;
                if (sent == RANDOM_ITEMS * 9 / 10) gaps_on = 1'b0;
                random_request(episode);
                sent++;
            end
        end
        s_tvalid <= 1'b0;

        // let outstanding results drain, then allow for a full search walk
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (results_due != 0) $error("%0d results never arrived", results_due);
        if (mismatch_count == 0 && results_due == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #6_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/bolist_pkg.sv
rtl/bolist_cell.sv
rtl/bounded_ordered_list_engine_core.sv
test/bolist_result_checker.sv
test/bounded_ordered_list_engine_core_tb.sv
